FILE: hdl/lru_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants and word types for the frame cells and the top level.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int FRAME_COUNT = 8;
    localparam int PAGE_BITS   = 8;
    localparam int COUNT_BITS  = 16;
    localparam int CFG_BITS    = 4;
    localparam int SLOT_BITS   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int AGE_BITS    = SLOT_BITS;
    localparam int USE_BITS    = $clog2(FRAME_COUNT + 1);

    localparam logic [AGE_BITS-1:0]   AGE_MAX     = AGE_BITS'(FRAME_COUNT - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
    localparam logic [CFG_BITS-1:0]   CFG_RESET   = CFG_BITS'(4);
    localparam logic [USE_BITS-1:0]   USE_MIN     = USE_BITS'(1);
    localparam logic [USE_BITS-1:0]   USE_MAX     = USE_BITS'(FRAME_COUNT);

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 last_ref;
    } lru_req_t;

    typedef struct packed {
        logic                  fault;
        logic [SLOT_BITS-1:0]  frame_slot;
        logic [COUNT_BITS-1:0] fault_count;
        logic                  string_done;
    } lru_rsp_t;

    // Search results passed from one cell to the next.
    typedef struct packed {
        logic                 hit_found;
        logic [SLOT_BITS-1:0] hit_idx;
        logic [AGE_BITS-1:0]  hit_age;
        logic                 empty_found;
        logic [SLOT_BITS-1:0] empty_idx;
        logic [AGE_BITS-1:0]  max_age;
        logic [SLOT_BITS-1:0] max_idx;
    } lru_chain_t;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic                 active;
        logic                 clear;
        logic                 hit;
        logic                 empty;
        logic [SLOT_BITS-1:0] slot;
        logic [AGE_BITS-1:0]  ref_age;
    } lru_upd_t;

endpackage

FILE: hdl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative frame set with least recently used replacement, built as
// a row of frame cells joined by a priority search chain.
// ----------------------------------------------------------------------------
// A page reference word is taken on req at a rising edge where start is high
// and busy is low. busy then stays high while the cell row
// searches for the page, picks a hit, empty or victim frame and updates the
// ranks. In the following cycle done is high for exactly one cycle and result
// carries the fault flag, the frame slot, the running fault count and the end
// of string mark. The receiver cannot stall, so every result word must be
// taken in that cycle. A new reference is not accepted while busy is high,
// and the search runs through all frame cells while busy is high.
// cfg_we with cfg_data sets the number of frames in use; write it only while
// idle. Reset empties all frames, clears the fault count and sets the number
// of frames in use to four. A reference marked as last clears the frames and
// the count once its result is produced.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lru_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lru_req_t            req,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_data,
    output logic                done,
    output lru_rsp_t            result
);

    logic                  busy_reg,   busy_next;
    logic                  done_reg,   done_next;
    lru_req_t              req_reg,    req_next;
    lru_rsp_t              result_reg, result_next;
    logic [COUNT_BITS-1:0] total_reg,  total_next;
    logic [CFG_BITS-1:0]   cfg_reg,    cfg_next;

    logic [USE_BITS-1:0]    used;
    lru_chain_t             chain [FRAME_COUNT+1];
    lru_chain_t             found;
    lru_upd_t               upd;
    logic [FRAME_COUNT-1:0] valid_vec;
    logic [COUNT_BITS-1:0]  count_new;

    always_comb
    begin
        if (cfg_reg == '0)
            used = USE_MIN;
        else if (USE_BITS'(cfg_reg) > USE_MAX)
            used = USE_MAX;
        else
            used = USE_BITS'(cfg_reg);
    end

    assign chain[0] = '0;
    assign found    = chain[FRAME_COUNT];

    genvar i;
    generate
        for (i = 0; i < FRAME_COUNT; i++)
        begin : g_cell
            lru_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (SLOT_BITS'(i)),
                .used      (used),
                .page      (req_reg.page),
                .chain_in  (chain[i]),
                .chain_out (chain[i+1]),
                .upd       (upd),
                .valid     (valid_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        upd.active = busy_reg;
        upd.clear  = req_reg.last_ref;
        upd.hit    = found.hit_found;
        upd.empty  = !found.hit_found && found.empty_found;
        if (found.hit_found)
        begin
            upd.slot    = found.hit_idx;
            upd.ref_age = found.hit_age;
        end
        else if (found.empty_found)
        begin
            upd.slot    = found.empty_idx;
            upd.ref_age = '0;
        end
        else
        begin
            upd.slot    = found.max_idx;
            upd.ref_age = found.max_age;
        end
    end

    always_comb
    begin
        if (!found.hit_found && total_reg != COUNT_MAX)
            count_new = total_reg + COUNT_BITS'(1);
        else
            count_new = total_reg;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        req_next    = req_reg;
        result_next = result_reg;
        total_next  = total_reg;
        cfg_next    = cfg_reg;
        if (cfg_we)
            cfg_next = cfg_data;
        if (busy_reg)
        begin
            busy_next               = 1'b0;
            done_next               = 1'b1;
            result_next.fault       = !found.hit_found;
            result_next.frame_slot  = upd.slot;
            result_next.fault_count = count_new;
            result_next.string_done = req_reg.last_ref;
            total_next              = req_reg.last_ref ? '0 : count_new;
        end
        else if (start)
        begin
            busy_next = 1'b1;
            req_next  = req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            total_reg <= '0;
            cfg_reg   <= CFG_RESET;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            total_reg <= total_next;
            cfg_reg   <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> done_reg)
        else $error("busy word did not complete in one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result strobe while still busy");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.string_done) |-> (valid_vec == '0 && total_reg == '0))
        else $error("frames not cleared after end of string");

    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !result_reg.string_done) |-> valid_vec[result_reg.frame_slot])
        else $error("reported frame does not hold a valid page");

    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && result_reg.fault) |-> (result_reg.fault_count != '0))
        else $error("fault reported with zero fault count");

endmodule

FILE: hdl/lru_cell.sv
// ----------------------------------------------------------------------------
// LRU frame cell
// Holds one frame's tag, valid mark and recency rank, extends the search
// chain from its left neighbor and applies the broadcast update.
// ----------------------------------------------------------------------------
module lru_cell
    import lru_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SLOT_BITS-1:0] cell_idx,
    input  logic [USE_BITS-1:0]  used,
    input  logic [PAGE_BITS-1:0] page,
    input  lru_chain_t           chain_in,
    output lru_chain_t           chain_out,
    input  lru_upd_t             upd,
    output logic                 valid
);

    logic [PAGE_BITS-1:0] tag_reg,   tag_next;
    logic                 valid_reg, valid_next;
    logic [AGE_BITS-1:0]  age_reg,   age_next;
    logic                 in_use;
    logic                 match;
    logic                 own_slot;

    assign in_use   = USE_BITS'(cell_idx) < used;
    assign match    = in_use && valid_reg && (tag_reg == page);
    assign own_slot = (upd.slot == cell_idx);
    assign valid    = valid_reg;

    always_comb
    begin
        chain_out = chain_in;
        if (match && !chain_in.hit_found)
        begin
            chain_out.hit_found = 1'b1;
            chain_out.hit_idx   = cell_idx;
            chain_out.hit_age   = age_reg;
        end
        if (in_use && !valid_reg && !chain_in.empty_found)
        begin
            chain_out.empty_found = 1'b1;
            chain_out.empty_idx   = cell_idx;
        end
        if (in_use && (age_reg > chain_in.max_age))
        begin
            chain_out.max_age = age_reg;
            chain_out.max_idx = cell_idx;
        end
    end

    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        age_next   = age_reg;
        if (upd.active)
        begin
            if (upd.clear)
            begin
                valid_next = 1'b0;
                age_next   = '0;
            end
            else if (own_slot)
            begin
                if (!upd.hit)
                begin
                    tag_next   = page;
                    valid_next = 1'b1;
                end
                age_next = '0;
            end
            else if (in_use && valid_reg && (upd.empty || age_reg < upd.ref_age)
                     && age_reg < AGE_MAX)
            begin
                age_next = age_reg + AGE_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule

FILE: tb/sv/tb_lru_page_replacement.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Sends page reference words through the start/busy handshake, predicts each
// result word with a local model of the frame set and its recency ranks, and
// compares every done word field by field. Directed tests cover filling,
// hits, eviction and frame count changes; random strings with pooled pages
// then run under several frame counts.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement
    import lru_pkg::*;
;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    lru_req_t            req;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_data;
    logic                done;
    lru_rsp_t            result;

    logic [PAGE_BITS-1:0]  frame_page [FRAME_COUNT];
    logic                  frame_full [FRAME_COUNT];
    logic [AGE_BITS-1:0]   frame_age  [FRAME_COUNT];
    logic [COUNT_BITS-1:0] string_faults;
    logic [CFG_BITS-1:0]   frames_setting;

    lru_rsp_t expected_words [$];
    int       mismatch_count;
    int       words_sent;
    int       words_checked;
    int       strings_ended;
    int       settings_used;
    bit       gaps_on;
    int       burst_left;

    lru_page_replacement i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void clear_frame_set();
        for (int j = 0; j < FRAME_COUNT; j++)
        begin
            frame_page[j] = '0;
            frame_full[j] = 1'b0;
            frame_age[j]  = '0;
        end
        string_faults = '0;
    endfunction

    function automatic void bump_ranks(input logic [AGE_BITS-1:0] limit, input int in_use,
                                       input bit every_frame);
        for (int j = 0; j < in_use; j++)
        begin
            if (frame_full[j] && (every_frame || frame_age[j] < limit) && frame_age[j] < AGE_MAX)
                frame_age[j] = frame_age[j] + 1'b1;
        end
    endfunction

    function automatic lru_rsp_t predict_reference(input lru_req_t w);
        lru_rsp_t r;
        int       in_use;
        int       slot;
        bit       hit;
        bit       empty;
        in_use = frames_setting;
        if (in_use < 1)
            in_use = 1;
        if (in_use > FRAME_COUNT)
            in_use = FRAME_COUNT;
        hit   = 1'b0;
        empty = 1'b0;
        slot  = 0;
        for (int j = 0; j < in_use; j++)
        begin
            if (!hit && frame_full[j] && frame_page[j] == w.page)
            begin
                hit  = 1'b1;
                slot = j;
            end
        end
        if (hit)
        begin
            bump_ranks(frame_age[slot], in_use, 1'b0);
        end
        else
        begin
            if (string_faults != COUNT_MAX)
                string_faults = string_faults + 1'b1;
            for (int j = 0; j < in_use; j++)
            begin
                if (!empty && !frame_full[j])
                begin
                    empty = 1'b1;
                    slot  = j;
                end
            end
            if (empty)
            begin
                bump_ranks('0, in_use, 1'b1);
            end
            else
            begin
                slot = 0;
                for (int j = 1; j < in_use; j++)
                begin
                    if (frame_age[j] > frame_age[slot])
                        slot = j;
                end
                bump_ranks(frame_age[slot], in_use, 1'b0);
            end
            frame_page[slot] = w.page;
            frame_full[slot] = 1'b1;
        end
        frame_age[slot] = '0;
        r.fault       = !hit;
        r.frame_slot  = SLOT_BITS'(slot);
        r.fault_count = string_faults;
        r.string_done = w.last_ref;
        if (w.last_ref)
            clear_frame_set();
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 20)
            $display("%0t: word %0d field %s is %0h, expected %0h",
                     $realtime, words_checked, field, got, want);
    endtask

    always @(posedge clk)
    begin : check_words
        lru_rsp_t want;
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("done without a pending word", 32'(done), 32'(1'b0));
            end
            else
            begin
                want = expected_words.pop_front();
                if (result.fault !== want.fault)
                    report_mismatch("fault", 32'(result.fault), 32'(want.fault));
                if (result.frame_slot !== want.frame_slot)
                    report_mismatch("frame_slot", 32'(result.frame_slot), 32'(want.frame_slot));
                if (result.fault_count !== want.fault_count)
                    report_mismatch("fault_count", 32'(result.fault_count),
                                    32'(want.fault_count));
                if (result.string_done !== want.string_done)
                    report_mismatch("string_done", 32'(result.string_done),
                                    32'(want.string_done));
                words_checked++;
            end
        end
    end

    // Entered and left at a falling edge; start is left high for a following word.
    task automatic send_reference(input logic [PAGE_BITS-1:0] page, input logic last);
        lru_req_t w;
        w.page     = page;
        w.last_ref = last;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        req   <= w;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_words.push_back(predict_reference(w));
        words_sent++;
        if (last)
            strings_ended++;
        @(negedge clk);
    endtask

    task automatic wait_for_idle();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic set_frames(input logic [CFG_BITS-1:0] value);
        wait_for_idle();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we         <= 1'b0;
        frames_setting = value;
        settings_used++;
    endtask

    task automatic test_basic_replacement();
        gaps_on = 1'b0;
        send_reference(8'h00, 1'b0);
        send_reference(8'hFF, 1'b0);
        send_reference(8'h00, 1'b0);
        send_reference(8'h55, 1'b0);
        send_reference(8'hAA, 1'b0);
        send_reference(8'h12, 1'b0);
        send_reference(8'hFF, 1'b0);
        send_reference(8'h00, 1'b0);
        send_reference(8'h12, 1'b1);
        send_reference(8'h00, 1'b1);
    endtask

    task automatic test_frame_count_changes();
        gaps_on = 1'b1;
        burst_left = 0;
        set_frames(4'd8);
        for (int i = 1; i <= 8; i++)
            send_reference(8'(i), 1'b0);
        set_frames(4'd2);
        send_reference(8'h20, 1'b0);
        send_reference(8'h21, 1'b0);
        send_reference(8'h05, 1'b0);
        set_frames(4'd8);
        send_reference(8'h05, 1'b0);
        for (int i = 0; i < 6; i++)
            send_reference(8'h30 + 8'(i), 1'b0);
        send_reference(8'h05, 1'b1);
    endtask

    task automatic test_random_strings();
        logic [CFG_BITS-1:0]  setting;
        logic [PAGE_BITS-1:0] pool_base;
        logic [PAGE_BITS-1:0] page;
        int                   pool_size;
        for (int phase = 0; phase < 11; phase++)
        begin
            case (phase)
                0: setting = 4'd0;
                1: setting = 4'd15;
                2: setting = 4'd1;
                3: setting = 4'd8;
                default: setting = 4'($urandom_range(0, 15));
            endcase
            set_frames(setting);
            gaps_on    = (phase % 3) != 1;
            burst_left = 0;
            pool_base  = 8'($urandom_range(0, 255));
            pool_size  = $urandom_range(2, 11);
            for (int i = 0; i < 46; i++)
            begin
                if (phase == 5 && i == 23)
                    wait_for_idle();
                if ($urandom_range(0, 3) != 0)
                    page = pool_base + 8'($urandom_range(0, pool_size - 1));
                else
                    page = 8'($urandom_range(0, 255));
                send_reference(page, $urandom_range(0, 11) == 0);
            end
            send_reference(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        cfg_we         = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        words_sent     = 0;
        words_checked  = 0;
        strings_ended  = 0;
        settings_used  = 0;
        gaps_on        = 1'b0;
        burst_left     = 0;
        clear_frame_set();
        frames_setting = CFG_RESET;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_replacement();
        test_frame_count_changes();
        test_random_strings();
        wait_for_idle();

        $display("Sent %0d reference words and checked %0d result words over %0d strings.",
                 words_sent, words_checked, strings_ended);
        $display("Wrote %0d frame counts, including out of range ones, with and without gaps.",
                 settings_used);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
